FILE: rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared constants: configuration register indexes, port widths and the
// saturation level of the magnitude.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W     = 8;
    localparam int MAG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [MAG_W-1:0] MAG_MAX = 8'd255;

endpackage

FILE: rtl/sobel_edge_magnitude_top.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streaming 3x3 Sobel gradient magnitude over a raster of grey pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on pix_valid/pix_stall in raster order, one item per pixel.
//   Results leave on res_valid/res_stall; each carries its own row and column
//   since output trails the input by one row and one column. An input item
//   gives zero to three results; run_last marks the last of them, frame_last
//   the result for the bottom-right pixel of the frame.
//   One item is processed at a time. An item passes through the line store
//   read, the gradient, the squaring and the bit-at-a-time square root, which
//   is what bounds the rate, and then emits its results one per emit step; the
//   square root is skipped when no gradient is needed (top rows, first column).
//   A registered output stage holds the last result, so the next pixel is
//   taken while that result waits on res_stall. A stalled receiver holds the
//   sequencer in its emit step and so pushes back on the pixel channel.
//   Configuration (image_width, image_height) is written on cfg_valid/
//   cfg_ready while idle with no result waiting, and holds off the pixel
//   channel in that cycle; a write to either register restarts the frame.
//   Reset restores 640 x 480 and starts at row 0, column 0. The line stores
//   are not cleared: their contents only reach results once written.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  logic [PIX_W-1:0]     pixel,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [MAG_W-1:0]     magnitude,
    output logic [ROW_W-1:0]     out_row,
    output logic [COL_W-1:0]     out_col,
    output logic                 run_last,
    output logic                 frame_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SQUARE,
        S_ROOT,
        S_EMIT
    } state_t;

    // bit positions of the pending result mask, in emission order
    localparam int K_TOP    = 0;
    localparam int K_MAG    = 1;
    localparam int K_EDGE   = 2;
    localparam int K_BOTTOM = 3;

    state_t                state_reg;
    logic [WIDTH_W-1:0]    image_width_reg;
    logic [HEIGHT_W-1:0]   image_height_reg;
    logic [COL_W-1:0]      col_count_reg;
    logic [ROW_W-1:0]      row_count_reg;
    logic [PIX_W-1:0]      win_reg [6];

    logic [PIX_W-1:0]      pix_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic                  col_one_reg;
    logic                  col_last_reg;
    logic [3:0]            pending_reg;

    logic signed [11:0]    gx_reg;
    logic signed [11:0]    gy_reg;
    logic [21:0]           sum_reg;
    logic [7:0]            root_reg;
    logic [7:0]            rbit_reg;

    logic                  res_valid_reg;
    logic [MAG_W-1:0]      magnitude_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [COL_W-1:0]      out_col_reg;
    logic                  run_last_reg;
    logic                  frame_last_reg;

    logic [PIX_W-1:0]      prev_mem  [MAX_WIDTH];
    logic [PIX_W-1:0]      older_mem [MAX_WIDTH];
    logic [PIX_W-1:0]      prev_rd_reg;
    logic [PIX_W-1:0]      older_rd_reg;

    logic                  cfg_write;
    logic                  pix_accept;
    logic                  out_free;
    logic [COL_W-1:0]      last_col;
    logic [ROW_W-1:0]      last_row;
    logic [3:0]            pending_next;
    logic signed [11:0]    gx_c;
    logic signed [11:0]    gy_c;
    logic signed [23:0]    sqx_c;
    logic signed [23:0]    sqy_c;
    logic [7:0]            trial_c;
    logic [15:0]           trial_sq_c;
    logic [3:0]            sel_c;
    logic [MAG_W-1:0]      sel_mag_c;
    logic [ROW_W-1:0]      sel_row_c;
    logic [COL_W-1:0]      sel_col_c;
    logic                  sel_frame_c;

    // clamp the configured size into the supported range
    always_comb
    begin
        if (image_width_reg < 12'd3)
            last_col = COL_W'(2);
        else if (32'(image_width_reg) > MAX_WIDTH)
            last_col = COL_W'(MAX_WIDTH - 1);
        else
            last_col = COL_W'(image_width_reg - 12'd1);

        if (image_height_reg < 13'd3)
            last_row = ROW_W'(2);
        else if (32'(image_height_reg) > MAX_HEIGHT)
            last_row = ROW_W'(MAX_HEIGHT - 1);
        else
            last_row = ROW_W'(image_height_reg - 13'd1);
    end

    assign cfg_ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign cfg_write  = cfg_valid && cfg_ready;
    // hold the pixel off while a configuration write is taken
    assign pix_stall  = (state_reg != S_IDLE) || cfg_write;
    assign pix_accept = pix_valid && !pix_stall;
    assign out_free   = !res_valid_reg || !res_stall;

    // which results this pixel gives, in order
    always_comb
    begin
        pending_next           = 4'd0;
        pending_next[K_TOP]    = (row_count_reg == '0);
        pending_next[K_MAG]    = (row_count_reg > ROW_W'(1)) && (col_count_reg != '0);
        pending_next[K_EDGE]   = (row_count_reg > ROW_W'(1)) && (col_count_reg == last_col);
        pending_next[K_BOTTOM] = (row_count_reg > ROW_W'(1)) && (row_count_reg == last_row);
    end

    // gradients from the two held columns and the column just read
    always_comb
    begin
        gx_c = {4'd0, older_rd_reg} - {4'd0, win_reg[0]}
             + {3'd0, prev_rd_reg, 1'b0} - {3'd0, win_reg[1], 1'b0}
             + {4'd0, pix_reg} - {4'd0, win_reg[2]};
        gy_c = {4'd0, win_reg[0]} + {3'd0, win_reg[3], 1'b0} + {4'd0, older_rd_reg}
             - {4'd0, win_reg[2]} - {3'd0, win_reg[5], 1'b0} - {4'd0, pix_reg};
        sqx_c = gx_reg * gx_reg;
        sqy_c = gy_reg * gy_reg;
        trial_c    = root_reg | rbit_reg;
        trial_sq_c = trial_c * trial_c;
    end

    // pick the earliest pending result
    always_comb
    begin
        sel_c       = 4'd0;
        sel_mag_c   = '0;
        sel_row_c   = row_reg;
        sel_col_c   = col_reg;
        sel_frame_c = 1'b0;
        if (pending_reg[K_TOP])
        begin
            sel_c[K_TOP] = 1'b1;
        end
        else if (pending_reg[K_MAG])
        begin
            sel_c[K_MAG] = 1'b1;
            sel_row_c    = row_reg - ROW_W'(1);
            sel_col_c    = col_reg - COL_W'(1);
            if (!col_one_reg)
                sel_mag_c = (|sum_reg[21:16]) ? MAG_MAX : root_reg;
        end
        else if (pending_reg[K_EDGE])
        begin
            sel_c[K_EDGE] = 1'b1;
            sel_row_c     = row_reg - ROW_W'(1);
        end
        else if (pending_reg[K_BOTTOM])
        begin
            sel_c[K_BOTTOM] = 1'b1;
            sel_frame_c     = col_last_reg;
        end
    end

    // line stores: read on accept, write back once the column is in hand
    always_ff @(posedge clk)
    begin
        if (pix_accept)
            prev_rd_reg <= prev_mem[col_count_reg];
        if (state_reg == S_READ)
            prev_mem[col_reg] <= pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
            older_rd_reg <= older_mem[col_count_reg];
        if (state_reg == S_READ)
            older_mem[col_reg] <= prev_rd_reg;
    end

    // item payload and arithmetic
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            pix_reg      <= pixel;
            col_reg      <= col_count_reg;
            row_reg      <= row_count_reg;
            col_one_reg  <= (col_count_reg == COL_W'(1));
            col_last_reg <= (col_count_reg == last_col);
        end
        if (state_reg == S_READ)
        begin
            gx_reg <= gx_c;
            gy_reg <= gy_c;
        end
        if (state_reg == S_SQUARE)
        begin
            sum_reg  <= sqx_c[21:0] + sqy_c[21:0];
            root_reg <= '0;
            rbit_reg <= 8'h80;
        end
        if (state_reg == S_ROOT)
        begin
            if (trial_sq_c <= sum_reg[15:0])
                root_reg <= trial_c;
            rbit_reg <= rbit_reg >> 1;
        end
        if (state_reg == S_EMIT && out_free && sel_c != 4'd0)
        begin
            magnitude_reg  <= sel_mag_c;
            out_row_reg    <= sel_row_c;
            out_col_reg    <= sel_col_c;
            run_last_reg   <= (pending_reg & ~sel_c) == 4'd0;
            frame_last_reg <= sel_frame_c;
        end
    end

    // sequencer, counters, window and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            pending_reg      <= '0;
            res_valid_reg    <= 1'b0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (state_reg == S_EMIT && pending_reg != 4'd0 && out_free)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_write && (cfg_index == CFG_IMAGE_WIDTH ||
                                      cfg_index == CFG_IMAGE_HEIGHT))
                    begin
                        if (cfg_index == CFG_IMAGE_WIDTH)
                            image_width_reg <= cfg_data[WIDTH_W-1:0];
                        else
                            image_height_reg <= cfg_data;
                        // restart the frame
                        col_count_reg <= '0;
                        row_count_reg <= '0;
                        for (int i = 0; i < 6; i++)
                            win_reg[i] <= '0;
                    end
                    else if (pix_accept)
                    begin
                        pending_reg <= pending_next;
                        if (col_count_reg == last_col)
                        begin
                            col_count_reg <= '0;
                            row_count_reg <= (row_count_reg == last_row) ? '0
                                           : row_count_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_count_reg <= col_count_reg + COL_W'(1);
                        end
                        state_reg <= S_READ;
                    end
                end

                S_READ:
                begin
                    // shift the window by one column
                    win_reg[0] <= win_reg[3];
                    win_reg[1] <= win_reg[4];
                    win_reg[2] <= win_reg[5];
                    win_reg[3] <= older_rd_reg;
                    win_reg[4] <= prev_rd_reg;
                    win_reg[5] <= pix_reg;
                    state_reg  <= S_SQUARE;
                end

                S_SQUARE:
                begin
                    state_reg <= pending_reg[K_MAG] ? S_ROOT : S_EMIT;
                end

                S_ROOT:
                begin
                    if (rbit_reg[0])
                        state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (pending_reg == 4'd0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        pending_reg <= pending_reg & ~sel_c;
                        if ((pending_reg & ~sel_c) == 4'd0)
                            state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid  = res_valid_reg;
    assign magnitude  = magnitude_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign run_last   = run_last_reg;
    assign frame_last = frame_last_reg;

endmodule

FILE: rtl/sem_checker.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude checker
// Port-level checks on the result stream and the pixel handshake.
// ----------------------------------------------------------------------------
module sem_checker
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             pix_valid,
    input logic             pix_stall,
    input logic [PIX_W-1:0] pixel,
    input logic             res_valid,
    input logic             res_stall,
    input logic [MAG_W-1:0] magnitude,
    input logic [ROW_W-1:0] out_row,
    input logic [COL_W-1:0] out_col,
    input logic             run_last,
    input logic             frame_last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(magnitude)
            && $stable(out_row) && $stable(out_col) && $stable(run_last)
            && $stable(frame_last))
        else $error("stalled result changed");

    // a stalled pixel holds
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pixel))
        else $error("stalled pixel changed");

    // one item at a time: an accepted pixel closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall |=> pix_stall)
        else $error("pixel taken while previous item in flight");

    // the frame's final result is also the last of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_last |-> run_last)
        else $error("frame_last without run_last");

    // the frame ends at a bottom-right corner, never on row or column zero, with a zero magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_last |-> out_row != '0 && out_col != '0 && magnitude == '0)
        else $error("frame_last on a bad position");

endmodule

bind sobel_edge_magnitude_top sem_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_sem_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pixel      (pixel),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .magnitude  (magnitude),
    .out_row    (out_row),
    .out_col    (out_col),
    .run_last   (run_last),
    .frame_last (frame_last)
);
